FILE: rtl/bond_graph_fragment_walk_top_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef BOND_GRAPH_FRAGMENT_WALK_TOP_MACROS_SVH
`define BOND_GRAPH_FRAGMENT_WALK_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define BGFW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define BGFW_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BGFW_ASSERT(lbl, clk, rstn, prop, msg)
`define BGFW_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/bgfw_pkg.sv
package bgfw_pkg;

  localparam int unsigned ATOM_W        = 6;
  localparam int unsigned CNT_W         = 4;
  localparam int unsigned REQ_W         = 2;
  localparam int unsigned NUM_ATOMS_DEF = 64;
  localparam int unsigned MAX_BONDS_DEF = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD         = 2'd0,
    REQ_WALK        = 2'd1,
    REQ_CLR_BONDS   = 2'd2,
    REQ_CLR_VISITED = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RDA,
    ST_ADD_RDB,
    ST_ADD_CHK,
    ST_ADD_WLA,
    ST_ADD_WCA,
    ST_ADD_WLB,
    ST_ADD_WCB,
    ST_RESP,
    ST_POP,
    ST_POP_WAIT,
    ST_CNT_WAIT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [ATOM_W-1:0] atom;
    logic              last;
    logic              status;
  } result_t;

endpackage

FILE: rtl/bond_graph_fragment_walk_top.sv
// Bond graph fragment walk. Each request beat carries a kind in tuser (add bond, walk from
// atom, clear bond counts, clear visited marks) and two atom numbers in tdata. Every request
// gives one result beat, except a walk, which gives the start atom and then every newly
// reached atom in depth-first pop order, tlast on the final one; tuser flags a dropped or
// rejected request. Visited marks persist across walks until cleared. Requests are taken one
// at a time. An add reads both bond counts, checks them and writes a list entry and a count
// for each atom. A walk pops each reached atom off a stack, reads its count and then each
// entry of its bond list; the lists and counts share one single-port memory that is read
// one entry per access. A result held at the output stalls the walk until it is taken.
`include "bond_graph_fragment_walk_top_macros.svh"

module bond_graph_fragment_walk_top #(
  parameter int unsigned NUM_ATOMS = bgfw_pkg::NUM_ATOMS_DEF,
  parameter int unsigned MAX_BONDS = bgfw_pkg::MAX_BONDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [5:0] atom_a, [11:6] atom_b, [15:12] zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [5:0] atom_out, [7:6] zero
  output logic        m_axis_tlast,
  output logic [0:0]  m_axis_tuser   // [0] status
);
  import bgfw_pkg::*;

  localparam int unsigned AIX_W     = $clog2(NUM_ATOMS);
  localparam int unsigned SP_W      = $clog2(NUM_ATOMS + 1);
  localparam int unsigned ADJ_ROW   = MAX_BONDS + 1;
  localparam int unsigned ADJ_DEPTH = NUM_ATOMS * ADJ_ROW;
  localparam int unsigned ADJ_AW    = $clog2(ADJ_DEPTH);
  localparam logic [CNT_W-1:0] CNT_SLOT = CNT_W'(MAX_BONDS);

  function automatic logic [ADJ_AW-1:0] adj_addr_f(input logic [ATOM_W-1:0] atom,
                                                   input logic [CNT_W-1:0]  slot);
    adj_addr_f = ADJ_AW'(ADJ_AW'(atom) * ADJ_AW'(ADJ_ROW)) + ADJ_AW'(slot);
  endfunction

  state_e               state_q, state_d;
  logic [ATOM_W-1:0]    a_q, a_d, b_q, b_d, cur_q, cur_d;
  logic [CNT_W-1:0]     cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d, cnt_q, cnt_d, j_q, j_d;
  logic [SP_W-1:0]      sp_q, sp_d, sp_m1;
  logic                 status_q, status_d;
  logic [NUM_ATOMS-1:0] visited_q, visited_d, cv_q, cv_d;

  logic [ATOM_W-1:0]    in_a, in_b, other;
  logic                 in_a_oor, in_b_oor;
  logic [CNT_W-1:0]     cnt_b_eff;
  logic [ADJ_AW-1:0]    adj_addr;
  logic                 adj_we;
  logic [ATOM_W-1:0]    adj_wdata, adj_rdata;
  logic [AIX_W-1:0]     stk_addr;
  logic                 stk_we;
  logic [ATOM_W-1:0]    stk_wdata, stk_rdata;
  logic                 res_vld, out_free;
  result_t              res_d;

  assign in_a     = s_axis_tdata[ATOM_W-1:0];
  assign in_b     = s_axis_tdata[2*ATOM_W-1:ATOM_W];
  assign in_a_oor = {1'b0, in_a} >= (ATOM_W + 1)'(NUM_ATOMS);
  assign in_b_oor = {1'b0, in_b} >= (ATOM_W + 1)'(NUM_ATOMS);
  assign sp_m1    = sp_q - SP_W'(1);
  assign other    = adj_rdata;
  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    a_d       = a_q;
    b_d       = b_q;
    cur_d     = cur_q;
    cnt_a_d   = cnt_a_q;
    cnt_b_d   = cnt_b_q;
    cnt_d     = cnt_q;
    j_d       = j_q;
    sp_d      = sp_q;
    status_d  = status_q;
    visited_d = visited_q;
    cv_d      = cv_q;
    cnt_b_eff = (a_q == b_q) ? cnt_a_q + CNT_W'(1)
              : (cv_q[b_q[AIX_W-1:0]] ? adj_rdata[CNT_W-1:0] : '0);
    adj_addr  = adj_addr_f(a_q, CNT_SLOT);
    adj_we    = 1'b0;
    adj_wdata = b_q;
    stk_addr  = sp_m1[AIX_W-1:0];
    stk_we    = 1'b0;
    stk_wdata = in_a;
    res_vld   = 1'b0;
    res_d     = '0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          a_d      = in_a;
          b_d      = in_b;
          status_d = 1'b0;
          case (req_e'(s_axis_tuser))
            REQ_ADD: begin
              if (in_a_oor || in_b_oor) begin
                status_d = 1'b1;
                state_d  = ST_RESP;
              end else begin
                state_d = ST_ADD_RDA;
              end
            end
            REQ_WALK: begin
              if (in_a_oor) begin
                status_d = 1'b1;
                state_d  = ST_RESP;
              end else begin
                visited_d[in_a[AIX_W-1:0]] = 1'b1;
                stk_we   = 1'b1;
                stk_addr = '0;
                sp_d     = SP_W'(1);
                state_d  = ST_POP;
              end
            end
            REQ_CLR_BONDS: begin
              cv_d    = '0;
              state_d = ST_RESP;
            end
            default: begin
              visited_d = '0;
              state_d   = ST_RESP;
            end
          endcase
        end
      end
      ST_ADD_RDA: begin
        state_d = ST_ADD_RDB;
      end
      ST_ADD_RDB: begin
        cnt_a_d  = cv_q[a_q[AIX_W-1:0]] ? adj_rdata[CNT_W-1:0] : '0;
        adj_addr = adj_addr_f(b_q, CNT_SLOT);
        state_d  = ST_ADD_CHK;
      end
      ST_ADD_CHK: begin
        cnt_b_d = cnt_b_eff;
        if (cnt_a_q >= CNT_SLOT || cnt_b_eff >= CNT_SLOT) begin
          status_d = 1'b1;
          state_d  = ST_RESP;
        end else begin
          state_d = ST_ADD_WLA;
        end
      end
      ST_ADD_WLA: begin
        adj_addr  = adj_addr_f(a_q, cnt_a_q);
        adj_we    = 1'b1;
        adj_wdata = b_q;
        state_d   = ST_ADD_WCA;
      end
      ST_ADD_WCA: begin
        adj_we    = 1'b1;
        adj_wdata = ATOM_W'(CNT_W'(cnt_a_q + CNT_W'(1)));
        cv_d[a_q[AIX_W-1:0]] = 1'b1;
        state_d   = ST_ADD_WLB;
      end
      ST_ADD_WLB: begin
        adj_addr  = adj_addr_f(b_q, cnt_b_q);
        adj_we    = 1'b1;
        adj_wdata = a_q;
        state_d   = ST_ADD_WCB;
      end
      ST_ADD_WCB: begin
        adj_addr  = adj_addr_f(b_q, CNT_SLOT);
        adj_we    = 1'b1;
        adj_wdata = ATOM_W'(CNT_W'(cnt_b_q + CNT_W'(1)));
        cv_d[b_q[AIX_W-1:0]] = 1'b1;
        state_d   = ST_RESP;
      end
      ST_RESP: begin
        res_vld       = 1'b1;
        res_d.last    = 1'b1;
        res_d.status  = status_q;
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_POP: begin
        sp_d    = sp_m1;
        state_d = ST_POP_WAIT;
      end
      ST_POP_WAIT: begin
        cur_d    = stk_rdata;
        adj_addr = adj_addr_f(stk_rdata, CNT_SLOT);
        state_d  = ST_CNT_WAIT;
      end
      ST_CNT_WAIT: begin
        cnt_d   = cv_q[cur_q[AIX_W-1:0]] ? adj_rdata[CNT_W-1:0] : '0;
        j_d     = '0;
        state_d = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        if (j_q == cnt_q) begin
          state_d = ST_EMIT;
        end else begin
          adj_addr = adj_addr_f(cur_q, j_q);
          state_d  = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (!visited_q[other[AIX_W-1:0]]) begin
          visited_d[other[AIX_W-1:0]] = 1'b1;
          stk_we    = 1'b1;
          stk_addr  = sp_q[AIX_W-1:0];
          stk_wdata = other;
          sp_d      = sp_q + SP_W'(1);
        end
        j_d     = j_q + CNT_W'(1);
        state_d = ST_SCAN_RD;
      end
      ST_EMIT: begin
        res_vld    = 1'b1;
        res_d.atom = cur_q;
        res_d.last = (sp_q == '0);
        if (out_free) begin
          state_d = (sp_q == '0) ? ST_IDLE : ST_POP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sp_q      <= '0;
      visited_q <= '0;
      cv_q      <= '0;
    end else begin
      state_q   <= state_d;
      sp_q      <= sp_d;
      visited_q <= visited_d;
      cv_q      <= cv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    cur_q    <= cur_d;
    cnt_a_q  <= cnt_a_d;
    cnt_b_q  <= cnt_b_d;
    cnt_q    <= cnt_d;
    j_q      <= j_d;
    status_q <= status_d;
  end

  bgfw_ram #(
    .WIDTH (ATOM_W),
    .DEPTH (ADJ_DEPTH)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .addr_i  (adj_addr),
    .wdata_i (adj_wdata),
    .rdata_o (adj_rdata)
  );

  bgfw_ram #(
    .WIDTH (ATOM_W),
    .DEPTH (NUM_ATOMS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .addr_i  (stk_addr),
    .wdata_i (stk_wdata),
    .rdata_o (stk_rdata)
  );

  bgfw_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (res_vld),
    .res_i         (res_d),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  `BGFW_ASSERT(a_sp_bound, clk_i, rst_ni, sp_q <= SP_W'(NUM_ATOMS), "stack depth above atom count")
  `BGFW_ASSERT(a_idle_empty, clk_i, rst_ni, (state_q == ST_IDLE) |-> (sp_q == '0), "stack not empty when idle")
  `BGFW_ASSERT(a_cnt_range, clk_i, rst_ni, (state_q == ST_CNT_WAIT && cv_q[cur_q[AIX_W-1:0]]) |-> (adj_rdata <= ATOM_W'(MAX_BONDS)), "stored bond count above limit")
  `BGFW_ASSERT_RST(a_rst_idle, clk_i, (!rst_ni) |-> (state_q == ST_IDLE && cv_q == '0), "state not cleared in reset")

endmodule

FILE: rtl/bgfw_ram.sv
module bgfw_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bgfw_out_reg.sv
module bgfw_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  bgfw_pkg::result_t res_i,
  output logic              free_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,  // [5:0] atom_out, [7:6] zero
  output logic              m_axis_tlast,
  output logic [0:0]        m_axis_tuser   // [0] status
);
  import bgfw_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  always_comb begin
    free_o  = !valid_q || m_axis_tready;
    valid_d = valid_q;
    res_d   = res_q;
    if (free_o && load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {{(8 - ATOM_W){1'b0}}, res_q.atom};
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tuser  = res_q.status;

endmodule

FILE: verif/tb_bond_graph_fragment_walk_top.sv
`timescale 1ns / 1ps

module tb_bond_graph_fragment_walk_top;
  import bgfw_pkg::*;

  localparam int unsigned NATOMS       = NUM_ATOMS_DEF;
  localparam int unsigned NBONDS       = MAX_BONDS_DEF;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned RANDOM_ITEMS = 80;
  localparam int unsigned CALM_ITEMS   = 20;
  localparam int unsigned DRAIN_CYCLES = 50;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;  // [5:0] atom_a, [11:6] atom_b, [15:12] zero
  logic [1:0]  s_axis_tuser;  // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;  // [5:0] atom_out, [7:6] zero
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;  // [0] status

  logic [ATOM_W-1:0] neighbour_tab [NATOMS][NBONDS];
  logic [CNT_W-1:0]  bond_total [NATOMS];
  logic              atom_seen [NATOMS];
  result_t           predicted_beats [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned items_sent     = 0;
  bit          feed_gaps      = 1'b1;
  bit          drain_stalls   = 1'b1;

  bond_graph_fragment_walk_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic try_add_bond(logic [ATOM_W-1:0] a, logic [ATOM_W-1:0] b);
    int unsigned need_a;
    need_a = (a == b) ? 2 : 1;
    if (bond_total[a] + need_a > NBONDS || bond_total[b] + 1 > NBONDS) return 1'b1;
    neighbour_tab[a][bond_total[a]] = b;
    bond_total[a] = bond_total[a] + 1'b1;
    neighbour_tab[b][bond_total[b]] = a;
    bond_total[b] = bond_total[b] + 1'b1;
    return 1'b0;
  endfunction

  function automatic void predict_walk(logic [ATOM_W-1:0] start);
    logic [ATOM_W-1:0] lifo [NATOMS];
    logic [ATOM_W-1:0] cur;
    logic [ATOM_W-1:0] other;
    int unsigned       depth;
    int unsigned       reached;
    int unsigned       j;
    result_t           beat;
    depth = 0;
    reached = 0;
    lifo[depth] = start;
    depth++;
    atom_seen[start] = 1'b1;
    while (depth > 0 && reached < NATOMS) begin
      depth--;
      cur = lifo[depth];
      reached++;
      beat.atom = cur;
      beat.last = (reached == NATOMS);
      beat.status = 1'b0;
      for (j = 0; j < bond_total[cur]; j++) begin
        other = neighbour_tab[cur][j];
        if (!atom_seen[other] && depth < NATOMS) begin
          atom_seen[other] = 1'b1;
          lifo[depth] = other;
          depth++;
        end
      end
      if (depth == 0) beat.last = 1'b1;
      predicted_beats.push_back(beat);
    end
  endfunction

  task automatic send_request(req_e kind, logic [ATOM_W-1:0] a, logic [ATOM_W-1:0] b);
    result_t beat;
    if (feed_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, b, a};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    beat.atom = '0;
    beat.last = 1'b1;
    beat.status = 1'b0;
    case (kind)
      REQ_ADD: begin
        beat.status = try_add_bond(a, b);
        predicted_beats.push_back(beat);
      end
      REQ_WALK: begin
        predict_walk(a);
      end
      REQ_CLR_BONDS: begin
        foreach (bond_total[i]) bond_total[i] = '0;
        predicted_beats.push_back(beat);
      end
      default: begin
        foreach (atom_seen[i]) atom_seen[i] = 1'b0;
        predicted_beats.push_back(beat);
      end
    endcase
  endtask

  task automatic note_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch on %s: expected %0d, got %0d (cycle %0d)", what, want, got,
               cycle_count);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (predicted_beats.size() == 0) begin
        note_mismatch("beat with nothing pending, atom", 0, m_axis_tdata[ATOM_W-1:0]);
      end else begin
        want = predicted_beats.pop_front();
        if (m_axis_tdata[ATOM_W-1:0] !== want.atom)
          note_mismatch("atom_out", want.atom, m_axis_tdata[ATOM_W-1:0]);
        if (m_axis_tlast !== want.last)
          note_mismatch("last", want.last, m_axis_tlast);
        if (m_axis_tuser[0] !== want.status)
          note_mismatch("drop flag", want.status, m_axis_tuser[0]);
      end
    end
  end

  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (drain_stalls && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // fill atom 0 to the limit, then hit the full list from both sides
  task automatic test_bond_limits();
    send_request(REQ_ADD, 6'd0, 6'd63);
    send_request(REQ_ADD, 6'd42, 6'd0);
    send_request(REQ_ADD, 6'd0, 6'd21);
    send_request(REQ_ADD, 6'd0, 6'd1);
    send_request(REQ_ADD, 6'd0, 6'd2);
    send_request(REQ_ADD, 6'd0, 6'd3);
    send_request(REQ_ADD, 6'd0, 6'd4);
    send_request(REQ_ADD, 6'd0, 6'd0);
    send_request(REQ_ADD, 6'd0, 6'd7);
    send_request(REQ_ADD, 6'd0, 6'd8);
    send_request(REQ_ADD, 6'd8, 6'd0);
    send_request(REQ_ADD, 6'd9, 6'd9);
  endtask

  task automatic test_walks();
    send_request(REQ_WALK, 6'd0, 6'd63);
    send_request(REQ_WALK, 6'd0, 6'd0);
    send_request(REQ_WALK, 6'd9, 6'd42);
    send_request(REQ_WALK, 6'd63, 6'd21);
  endtask

  task automatic test_clears();
    send_request(REQ_CLR_VISITED, 6'd63, 6'd63);
    send_request(REQ_WALK, 6'd21, 6'd0);
    send_request(REQ_CLR_BONDS, 6'd0, 6'd0);
    send_request(REQ_WALK, 6'd0, 6'd0);
    send_request(REQ_CLR_VISITED, 6'd0, 6'd0);
    send_request(REQ_WALK, 6'd63, 6'd0);
  endtask

  task automatic test_random_fragments();
    logic [ATOM_W-1:0] members [8];
    int unsigned       base;
    int unsigned       size;
    int unsigned       i;
    int unsigned       reps;
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      if (items_sent - base >= RANDOM_ITEMS - CALM_ITEMS) begin
        feed_gaps = 1'b0;
        drain_stalls = 1'b0;
      end else begin
        feed_gaps = ($urandom_range(0, 3) != 0);
        drain_stalls = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 9) < 7) begin
        size = $urandom_range(2, 8);
        for (i = 0; i < size; i++) members[i] = ATOM_W'($urandom_range(0, NATOMS - 1));
        if ($urandom_range(0, 2) != 0)
          send_request(REQ_CLR_BONDS, ATOM_W'($urandom), ATOM_W'($urandom));
        if ($urandom_range(0, 1) != 0)
          send_request(REQ_CLR_VISITED, ATOM_W'($urandom), ATOM_W'($urandom));
        if ($urandom_range(0, 3) == 0) begin
          // star around one hub, 6 to 11 spokes, so that the larger counts overflow its list
          reps = $urandom_range(6, 11);
          for (i = 0; i < reps; i++)
            send_request(REQ_ADD, members[0], ATOM_W'($urandom_range(0, NATOMS - 1)));
        end else begin
          for (i = 0; i + 1 < size; i++) send_request(REQ_ADD, members[i], members[i + 1]);
          reps = $urandom_range(0, 3);
          for (i = 0; i < reps; i++)
            send_request(REQ_ADD, members[$urandom_range(0, size - 1)],
                         members[$urandom_range(0, size - 1)]);
        end
        reps = $urandom_range(1, 3);
        for (i = 0; i < reps; i++) begin
          if ($urandom_range(0, 2) == 0)
            send_request(REQ_CLR_VISITED, ATOM_W'($urandom), ATOM_W'($urandom));
          send_request(REQ_WALK, members[$urandom_range(0, size - 1)], ATOM_W'($urandom));
        end
      end else begin
        reps = $urandom_range(1, 4);
        for (i = 0; i < reps; i++)
          send_request(req_e'(REQ_W'($urandom_range(0, 3))), ATOM_W'($urandom),
                       ATOM_W'($urandom));
      end
    end
  endtask

  initial begin
    foreach (bond_total[i]) bond_total[i] = '0;
    foreach (atom_seen[i]) atom_seen[i] = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_ADD;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_bond_limits();
    test_walks();
    test_clears();
    test_random_fragments();

    s_axis_tvalid <= 1'b0;
    while (predicted_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
